// File: rtl/core/plnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline nearest point package
// Shared constants and types for the polyline store and windowed search.
// ----------------------------------------------------------------------------
package plnp_pkg;

    // Store depth and derived widths.
    localparam int unsigned MAX_VERTICES = 1024;
    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

    // Field widths.
    localparam int unsigned COORD_W = 32;
    localparam int unsigned RANGE_W = 48;
    localparam int unsigned ARC_W   = 47;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned DSQ_W   = 66;
    localparam int unsigned ROOT_W  = 33;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT,
        ST_APP_RD,
        ST_APP_WAIT,
        ST_APP_SQRT
    } t_state;

    // One stored vertex.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ARC_W-1:0]          arc;
    } t_vertex;

endpackage

// File: rtl/core/plnp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline nearest point channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plnp_req_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                opcode;
    logic signed [plnp_pkg::COORD_W-1:0]       x;
    logic signed [plnp_pkg::COORD_W-1:0]       y;
    logic signed [plnp_pkg::COORD_W-1:0]       z;
    logic signed [plnp_pkg::RANGE_W-1:0]       range_start;
    logic signed [plnp_pkg::RANGE_W-1:0]       range_end;

    modport source (output valid, opcode, x, y, z, range_start, range_end, input ready);
    modport sink (input valid, opcode, x, y, z, range_start, range_end, output ready);
endinterface

interface plnp_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      found;
    logic [plnp_pkg::INDEX_W-1:0]              vertex_index;
    logic signed [plnp_pkg::COORD_W-1:0]       pos_x;
    logic signed [plnp_pkg::COORD_W-1:0]       pos_y;
    logic signed [plnp_pkg::COORD_W-1:0]       pos_z;
    logic [plnp_pkg::ARC_W-1:0]                arc_length;

    modport source (output valid, found, vertex_index, pos_x, pos_y, pos_z, arc_length,
                    input ready);
    modport sink (input valid, found, vertex_index, pos_x, pos_y, pos_z, arc_length,
                  output ready);
endinterface

// File: rtl/core/plnp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline vertex store
// One write port and one registered read port over the vertex memory.
// ----------------------------------------------------------------------------
module plnp_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [plnp_pkg::AW-1:0]     i_waddr,
    input  plnp_pkg::t_vertex           i_wdata,
    input  logic                        i_re,
    input  logic [plnp_pkg::AW-1:0]     i_raddr,
    output plnp_pkg::t_vertex           o_rdata
);

    plnp_pkg::t_vertex r_mem [plnp_pkg::MAX_VERTICES];
    plnp_pkg::t_vertex r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/plnp_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: absolute differences, squares, sum. One vertex per cycle.
// ----------------------------------------------------------------------------
module plnp_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  plnp_pkg::t_vertex                    i_vtx,
    input  logic [plnp_pkg::AW-1:0]              i_idx,
    input  logic signed [plnp_pkg::COORD_W-1:0]  i_px,
    input  logic signed [plnp_pkg::COORD_W-1:0]  i_py,
    input  logic signed [plnp_pkg::COORD_W-1:0]  i_pz,
    output logic                                 o_vld,
    output logic                                 o_busy,
    output plnp_pkg::t_vertex                    o_vtx,
    output logic [plnp_pkg::AW-1:0]              o_idx,
    output logic [plnp_pkg::DSQ_W-1:0]           o_dsq
);

    localparam int unsigned CW = plnp_pkg::COORD_W;
    localparam int unsigned SW = 2 * CW;

    logic                        r_v1, r_v2, r_v3;
    plnp_pkg::t_vertex           r_vtx1, r_vtx2, r_vtx3;
    logic [plnp_pkg::AW-1:0]     r_idx1, r_idx2, r_idx3;
    logic [CW-1:0]               r_dx, r_dy, r_dz;
    logic [SW-1:0]               r_sx, r_sy, r_sz;
    logic [plnp_pkg::DSQ_W-1:0]  r_sum;
    logic signed [CW:0]          n_ex, n_ey, n_ez;

    // Signed differences in one extra bit.
    always_comb begin
        n_ex = (CW+1)'(i_vtx.x) - (CW+1)'(i_px);
        n_ey = (CW+1)'(i_vtx.y) - (CW+1)'(i_py);
        n_ez = (CW+1)'(i_vtx.z) - (CW+1)'(i_pz);
    end

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Datapath: magnitudes, then squares, then the sum.
    always_ff @(posedge i_clk) begin
        r_dx   <= n_ex[CW] ? CW'(-n_ex) : CW'(n_ex);
        r_dy   <= n_ey[CW] ? CW'(-n_ey) : CW'(n_ey);
        r_dz   <= n_ez[CW] ? CW'(-n_ez) : CW'(n_ez);
        r_vtx1 <= i_vtx;
        r_idx1 <= i_idx;
        r_sx   <= SW'(r_dx) * SW'(r_dx);
        r_sy   <= SW'(r_dy) * SW'(r_dy);
        r_sz   <= SW'(r_dz) * SW'(r_dz);
        r_vtx2 <= r_vtx1;
        r_idx2 <= r_idx1;
        r_sum  <= plnp_pkg::DSQ_W'(r_sx) + plnp_pkg::DSQ_W'(r_sy)
                + plnp_pkg::DSQ_W'(r_sz);
        r_vtx3 <= r_vtx2;
        r_idx3 <= r_idx2;
    end

    assign o_vld  = r_v3;
    assign o_busy = r_v1 | r_v2 | r_v3;
    assign o_vtx  = r_vtx3;
    assign o_idx  = r_idx3;
    assign o_dsq  = r_sum;

endmodule

// File: rtl/core/plnp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
module plnp_isqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [plnp_pkg::DSQ_W-1:0]          i_val,
    output logic                                o_done,
    output logic [plnp_pkg::ROOT_W-1:0]         o_root
);

    localparam int unsigned RW = plnp_pkg::ROOT_W + 4;
    localparam int unsigned NW = $clog2(plnp_pkg::ROOT_W + 1);

    logic [NW-1:0]                 r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [plnp_pkg::DSQ_W-1:0]    r_val, n_val;
    logic [RW-1:0]                 r_rem, n_rem;
    logic [plnp_pkg::ROOT_W-1:0]   r_root, n_root;
    logic [RW-1:0]                 w_shift, w_trial;

    // One step: bring down two bits and try the next root bit.
    always_comb begin
        w_shift = {r_rem[RW-3:0], r_val[plnp_pkg::DSQ_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_val   = r_val;
        n_rem   = r_rem;
        n_root  = r_root;
        if (i_start) begin
            n_cnt  = NW'(plnp_pkg::ROOT_W);
            n_busy = 1'b1;
            n_val  = i_val;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_val = {r_val[plnp_pkg::DSQ_W-3:0], 2'b00};
            if (w_shift >= w_trial) begin
                n_rem  = w_shift - w_trial;
                n_root = {r_root[plnp_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_root = {r_root[plnp_pkg::ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/core/polyline_nearest_point_in_arc_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline nearest point in arc window
// Stores a 3-D polyline with cumulative arc lengths and finds the nearest
// vertex to a query point within a half-open arc-length window.
// ----------------------------------------------------------------------------
//  Channel  Dir  Modport  Content
//  i_req    in   sink     opcode, x, y, z, range_start, range_end
//  o_rsp    out  source   found, vertex_index, pos_x, pos_y, pos_z, arc_length
//
// During a query over N stored vertices, the scan reads one vertex per cycle
// from the store port into the squared-distance pipeline.
// An append of a later vertex waits on the 33-step square root unit; the
// first vertex, a clear and an unused opcode complete without leaving idle.
// Reset empties the store at once. i_req is ready only when idle, and a
// response holds until o_rsp.ready is high.
// ----------------------------------------------------------------------------
module polyline_nearest_point_in_arc_window_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    plnp_req_if.sink    i_req,
    plnp_rsp_if.source  o_rsp
);

    localparam int unsigned AW = plnp_pkg::AW;
    localparam int unsigned CW = plnp_pkg::CW;
    localparam int unsigned XW = AW + plnp_pkg::INDEX_W;

    plnp_pkg::t_state                      r_state, n_state;
    logic [CW-1:0]                         r_count, n_count;
    logic [CW-1:0]                         r_issue, n_issue;
    logic signed [plnp_pkg::COORD_W-1:0]   r_qx, r_qy, r_qz, n_qx, n_qy, n_qz;
    logic signed [plnp_pkg::RANGE_W-1:0]   r_lo, r_hi, n_lo, n_hi;
    logic                                  r_found, n_found;
    logic [AW-1:0]                         r_best_idx, n_best_idx;
    plnp_pkg::t_vertex                     r_best_vtx, n_best_vtx;
    logic [plnp_pkg::DSQ_W-1:0]            r_best_d, n_best_d;
    logic [plnp_pkg::ARC_W-1:0]            r_prev_arc, n_prev_arc;
    logic                                  r_p0_vld, n_p0_vld;
    logic [AW-1:0]                         r_p0_idx, n_p0_idx;

    logic                                  w_re, w_we;
    logic [AW-1:0]                         w_raddr, w_waddr;
    plnp_pkg::t_vertex                     w_wdata, w_rdata;
    logic                                  w_dvld, w_dbusy;
    plnp_pkg::t_vertex                     w_dvtx;
    logic [AW-1:0]                         w_didx;
    logic [plnp_pkg::DSQ_W-1:0]            w_dsq;
    logic                                  w_sq_start, w_sq_done;
    logic [plnp_pkg::ROOT_W-1:0]           w_root;
    logic signed [plnp_pkg::RANGE_W-1:0]   w_arc_s;
    logic                                  w_in_win;
    logic [plnp_pkg::ARC_W:0]              w_arc_sum;
    logic [XW-1:0]                         w_idx_ext;
    plnp_pkg::t_opcode                     w_op;

    // Vertex memory.
    plnp_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared squared-distance pipeline.
    plnp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p0_vld),
        .i_vtx   (w_rdata),
        .i_idx   (r_p0_idx),
        .i_px    (r_qx),
        .i_py    (r_qy),
        .i_pz    (r_qz),
        .o_vld   (w_dvld),
        .o_busy  (w_dbusy),
        .o_vtx   (w_dvtx),
        .o_idx   (w_didx),
        .o_dsq   (w_dsq)
    );

    // Segment length root.
    plnp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_dsq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_op      = plnp_pkg::t_opcode'(i_req.opcode);
    assign w_arc_s   = plnp_pkg::RANGE_W'(w_dvtx.arc);
    assign w_in_win  = (w_arc_s >= r_lo) && (w_arc_s < r_hi);
    assign w_arc_sum = (plnp_pkg::ARC_W+1)'(r_prev_arc) + (plnp_pkg::ARC_W+1)'(w_root);

    // Next state, memory control and best-candidate tracking.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_qx       = r_qx;
        n_qy       = r_qy;
        n_qz       = r_qz;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_vtx = r_best_vtx;
        n_best_d   = r_best_d;
        n_prev_arc = r_prev_arc;
        n_p0_vld   = 1'b0;
        n_p0_idx   = r_p0_idx;
        w_re       = 1'b0;
        w_raddr    = r_issue[AW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_count[AW-1:0];
        w_wdata    = '{x: r_qx, y: r_qy, z: r_qz, arc: '0};
        w_sq_start = 1'b0;
        i_req.ready = (r_state == plnp_pkg::ST_IDLE);

        unique case (r_state)
            plnp_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_qx = i_req.x;
                    n_qy = i_req.y;
                    n_qz = i_req.z;
                    n_lo = i_req.range_start;
                    n_hi = i_req.range_end;
                    unique case (w_op)
                        plnp_pkg::OP_APPEND: begin
                            if (r_count == CW'(0)) begin
                                // First vertex starts at arc length zero.
                                w_we    = 1'b1;
                                w_wdata = '{x: i_req.x, y: i_req.y, z: i_req.z, arc: '0};
                                n_count = CW'(1);
                            end else if (r_count < CW'(plnp_pkg::MAX_VERTICES)) begin
                                n_state = plnp_pkg::ST_APP_RD;
                            end
                        end
                        plnp_pkg::OP_QUERY: begin
                            n_issue    = '0;
                            n_found    = 1'b0;
                            n_best_idx = '0;
                            n_best_vtx = '0;
                            n_best_d   = '0;
                            n_state    = plnp_pkg::ST_SCAN;
                        end
                        plnp_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            plnp_pkg::ST_SCAN: begin
                if (r_issue == r_count) begin
                    n_state = plnp_pkg::ST_DRAIN;
                end else begin
                    w_re     = 1'b1;
                    n_p0_vld = 1'b1;
                    n_p0_idx = r_issue[AW-1:0];
                    n_issue  = r_issue + CW'(1);
                end
            end
            plnp_pkg::ST_DRAIN: begin
                if (!r_p0_vld && !w_dbusy) begin
                    n_state = plnp_pkg::ST_RESULT;
                end
            end
            plnp_pkg::ST_RESULT: begin
                if (o_rsp.ready) begin
                    n_state = plnp_pkg::ST_IDLE;
                end
            end
            plnp_pkg::ST_APP_RD: begin
                // Fetch the previous vertex for the segment length.
                w_re     = 1'b1;
                w_raddr  = AW'(r_count - CW'(1));
                n_p0_vld = 1'b1;
                n_state  = plnp_pkg::ST_APP_WAIT;
            end
            plnp_pkg::ST_APP_WAIT: begin
                if (w_dvld) begin
                    w_sq_start = 1'b1;
                    n_prev_arc = w_dvtx.arc;
                    n_state    = plnp_pkg::ST_APP_SQRT;
                end
            end
            plnp_pkg::ST_APP_SQRT: begin
                if (w_sq_done) begin
                    w_we = 1'b1;
                    w_wdata.arc = w_arc_sum[plnp_pkg::ARC_W] ? '1
                                : w_arc_sum[plnp_pkg::ARC_W-1:0];
                    n_count = r_count + CW'(1);
                    n_state = plnp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plnp_pkg::ST_IDLE;
            end
        endcase

        // Keep the first strictly nearer vertex inside the window.
        if ((r_state == plnp_pkg::ST_SCAN || r_state == plnp_pkg::ST_DRAIN)
                && w_dvld && w_in_win && (!r_found || w_dsq < r_best_d)) begin
            n_found    = 1'b1;
            n_best_idx = w_didx;
            n_best_vtx = w_dvtx;
            n_best_d   = w_dsq;
        end
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plnp_pkg::ST_IDLE;
            r_count  <= '0;
            r_issue  <= '0;
            r_found  <= 1'b0;
            r_p0_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_found  <= n_found;
            r_p0_vld <= n_p0_vld;
        end
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_qz       <= n_qz;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_best_idx <= n_best_idx;
        r_best_vtx <= n_best_vtx;
        r_best_d   <= n_best_d;
        r_prev_arc <= n_prev_arc;
        r_p0_idx   <= n_p0_idx;
    end

    // Response fields; all zero when nothing was in the window.
    assign w_idx_ext          = XW'(r_best_idx);
    assign o_rsp.valid        = (r_state == plnp_pkg::ST_RESULT);
    assign o_rsp.found        = r_found;
    assign o_rsp.vertex_index = w_idx_ext[plnp_pkg::INDEX_W-1:0];
    assign o_rsp.pos_x        = r_best_vtx.x;
    assign o_rsp.pos_y        = r_best_vtx.y;
    assign o_rsp.pos_z        = r_best_vtx.z;
    assign o_rsp.arc_length   = r_best_vtx.arc;

endmodule
